FILE: hw/rtl/kbdfifo_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard scancode FIFO package
// Shared widths, command codes and parameter defaults for the scancode FIFO.
// ----------------------------------------------------------------------------
package kbdfifo_pkg;

  // Field widths of one input item and one result item.
  localparam int CMD_W  = 3;
  localparam int KEY_W  = 9;
  localparam int CODE_W = 7;
  localparam int LAST_W = 8;

  // Parameter defaults.
  localparam int FIFO_DEPTH_DEF  = 16;
  localparam int MAP_ENTRIES_DEF = 512;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_KEY_DOWN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_KEY_UP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_IRQ_ACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MAP_WRITE = 3'd4;

endpackage

FILE: hw/rtl/keymap_scancode_fifo_with_irq.sv
// ----------------------------------------------------------------------------
// Keyboard scancode FIFO with interrupt handshake
// Translates host key numbers to scancodes, queues them and hands them out
// one per tick with an interrupt and acknowledge handshake.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle once it is running, unless a
// stalled result holds the working stage. The keymap RAM is read at the input
// transfer itself, and when the item leaves the working stage it updates the
// FIFO and flags and loads the result register. After reset the block sweeps
// the keymap RAM to zero through its single write port, one entry per cycle,
// so in_ready stays low until every entry is cleared. FIFO_DEPTH must be a
// power of two; the FIFO holds at most FIFO_DEPTH-1 codes.
// ----------------------------------------------------------------------------
module keymap_scancode_fifo_with_irq #(
  parameter int FIFO_DEPTH  = kbdfifo_pkg::FIFO_DEPTH_DEF,
  parameter int MAP_ENTRIES = kbdfifo_pkg::MAP_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kbdfifo_pkg::CMD_W-1:0]  in_cmd,
  input  logic [kbdfifo_pkg::KEY_W-1:0]  in_host_key,
  input  logic [kbdfifo_pkg::CODE_W-1:0] in_map_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kbdfifo_pkg::LAST_W-1:0] out_last_key,
  output logic                          out_irq_raise,
  output logic                          out_irq_pending,
  output logic                          out_accepted
);

  import kbdfifo_pkg::*;

  localparam int MAP_AW  = $clog2(MAP_ENTRIES);
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int CMP_W   = ((KEY_W > MAP_AW) ? KEY_W : MAP_AW) + 1;

  // Keymap clearing sweep after reset.
  logic              busy_r;
  logic [MAP_AW-1:0] clr_addr_r;

  // Working stage holding the item whose keymap read is in flight.
  logic              s1_v_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic [CODE_W-1:0] s1_val_r;

  // Keymap write bypass for a read issued while that write completed.
  logic              kb_v_r;
  logic [KEY_W-1:0]  kb_key_r;
  logic [CODE_W-1:0] kb_val_r;

  // FIFO head bypass for a read issued while the same slot was written.
  logic              ff_v_r;
  logic              ff_v_nxt;
  logic [LAST_W-1:0] ff_d_r;

  // Architectural state.
  logic [FIFO_AW-1:0] wptr_r, wptr_nxt;
  logic [FIFO_AW-1:0] rptr_r, rptr_nxt;
  logic               pend_r, pend_nxt;
  logic [LAST_W-1:0]  last_r, last_nxt;

  // Result register.
  logic              out_v_r;
  logic [LAST_W-1:0] out_last_r;
  logic              out_raise_r;
  logic              out_pend_r;
  logic              out_acc_r;

  // Datapath signals.
  logic               s1_fire;
  logic               in_fire;
  logic [CMP_W-1:0]   in_key_ext;
  logic [CMP_W-1:0]   s1_key_ext;
  logic               s1_in_range;
  logic [CODE_W-1:0]  km_rdata;
  logic [CODE_W-1:0]  code;
  logic               is_key;
  logic               map_wr;
  logic [FIFO_AW-1:0] wptr_inc;
  logic               push;
  logic [LAST_W-1:0]  push_data;
  logic [LAST_W-1:0]  ff_rdata;
  logic [LAST_W-1:0]  head;
  logic               raise;
  logic               km_we;
  logic [MAP_AW-1:0]  km_waddr;
  logic [CODE_W-1:0]  km_wdata;

  // Handshake.
  assign s1_fire  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !busy_r && (!s1_v_r || s1_fire);
  assign in_fire  = in_valid && in_ready;

  // Key range check and RAM addresses.
  assign in_key_ext  = CMP_W'(in_host_key);
  assign s1_key_ext  = CMP_W'(s1_key_r);
  assign s1_in_range = (s1_key_ext < CMP_W'(MAP_ENTRIES));

  // Scancode lookup with write bypass; out-of-range keys read as unmapped.
  always_comb begin
    if (!s1_in_range) begin
      code = '0;
    end else if (kb_v_r && (kb_key_r == s1_key_r)) begin
      code = kb_val_r;
    end else begin
      code = km_rdata;
    end
  end

  assign is_key    = (s1_cmd_r == CMD_KEY_DOWN) || (s1_cmd_r == CMD_KEY_UP);
  assign map_wr    = s1_fire && (s1_cmd_r == CMD_MAP_WRITE) && s1_in_range;
  assign wptr_inc  = wptr_r + 1'b1;
  assign push      = s1_fire && is_key && (code != '0) && (wptr_inc != rptr_r);
  assign push_data = {(s1_cmd_r == CMD_KEY_UP), code};
  assign head      = ff_v_r ? ff_d_r : ff_rdata;

  // Next state of pointers, pending flag and last-key register.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    pend_nxt = pend_r;
    last_nxt = last_r;
    raise    = 1'b0;
    if (push) begin
      wptr_nxt = wptr_inc;
    end
    if (s1_fire) begin
      unique case (s1_cmd_r)
        CMD_TICK: begin
          if (rptr_r != wptr_r) begin
            if (!pend_r) begin
              last_nxt = head;
              rptr_nxt = rptr_r + 1'b1;
              pend_nxt = 1'b1;
              raise    = 1'b1;
            end
          end else if (!pend_r) begin
            last_nxt = '0;
          end
        end
        CMD_IRQ_ACK: begin
          pend_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // The FIFO read port always fetches the slot that will be the head.
  assign ff_v_nxt = push && (wptr_r == rptr_nxt);

  // Keymap write port is shared by the clearing sweep and map writes.
  assign km_we    = busy_r || map_wr;
  assign km_waddr = busy_r ? clr_addr_r : s1_key_ext[MAP_AW-1:0];
  assign km_wdata = busy_r ? '0 : s1_val_r;

  kbdfifo_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAP_ENTRIES)
  ) u_keymap (
    .clk   (clk),
    .we    (km_we),
    .waddr (km_waddr),
    .wdata (km_wdata),
    .re    (in_fire),
    .raddr (in_key_ext[MAP_AW-1:0]),
    .rdata (km_rdata)
  );

  kbdfifo_ram #(
    .WIDTH (LAST_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .we    (push),
    .waddr (wptr_r),
    .wdata (push_data),
    .re    (1'b1),
    .raddr (rptr_nxt),
    .rdata (ff_rdata)
  );

  // Clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == MAP_AW'(MAP_ENTRIES - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Working stage and keymap bypass, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      kb_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
        kb_v_r <= map_wr;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_cmd;
      s1_key_r <= in_host_key;
      s1_val_r <= in_map_value;
      kb_key_r <= s1_key_r;
      kb_val_r <= s1_val_r;
    end
  end

  // Architectural state and FIFO head bypass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      pend_r <= 1'b0;
      last_r <= '0;
      ff_v_r <= 1'b0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      pend_r <= pend_nxt;
      last_r <= last_nxt;
      ff_v_r <= ff_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ff_d_r <= push_data;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_last_r  <= last_nxt;
      out_raise_r <= raise;
      out_pend_r  <= pend_nxt;
      out_acc_r   <= push;
    end
  end

  assign out_valid       = out_v_r;
  assign out_last_key    = out_last_r;
  assign out_irq_raise   = out_raise_r;
  assign out_irq_pending = out_pend_r;
  assign out_accepted    = out_acc_r;

endmodule

FILE: hw/rtl/kbdfifo_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kbdfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/kbdfifo_chk.sv
// ----------------------------------------------------------------------------
// Keyboard scancode FIFO checker
// Port-level assertions for the scancode FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module kbdfifo_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kbdfifo_pkg::LAST_W-1:0] out_last_key,
  input logic                          out_irq_raise,
  input logic                          out_irq_pending,
  input logic                          out_accepted
);

  // Reset starts the keymap sweep: no transfer either way in the next cycle.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!in_ready && !out_valid))
    else $error("transfer possible right after reset");

  // A raised interrupt always leaves the pending flag set.
  a_raise_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq_raise) |-> out_irq_pending)
    else $error("interrupt raised without pending flag");

  // A raise pops a queued code, which is never zero, and is not a key push.
  a_raise_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq_raise) |-> ((out_last_key != '0) && !out_accepted))
    else $error("interrupt raised with empty code or alongside a push");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_last_key) &&
      $stable(out_irq_raise) && $stable(out_irq_pending) && $stable(out_accepted)))
    else $error("result changed while stalled");

  // The result-side ready is known whenever an input transfer takes place.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !$isunknown(out_ready))
    else $error("unknown out_ready during an input transfer");

endmodule

bind keymap_scancode_fifo_with_irq kbdfifo_chk u_kbdfifo_chk (.*);
